@@ hw/rtl/imhdp_pkg.sv @@
package imhdp_pkg;
    localparam int NODES      = 1024;
    localparam int SCORE_BITS = 16;
    localparam int NODE_W     = 10;
    localparam int CNT_W      = 11;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_DEC    = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    typedef struct packed {
        logic [1:0]            action;
        logic [NODE_W-1:0]     node;
        logic [SCORE_BITS-1:0] score;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0]     min_node;
        logic [SCORE_BITS-1:0] min_score;
        logic [CNT_W-1:0]      count;
        logic                  empty_res;
    } t_out;

    typedef struct packed {
        logic                  we;
        logic [NODE_W-1:0]     waddr;
        logic [NODE_W-1:0]     wdata;
        logic [NODE_W-1:0]     raddr;
    } t_hreq;

    typedef struct packed {
        logic                  we;
        logic [NODE_W-1:0]     waddr;
        logic [NODE_W-1:0]     wpos;
        logic [SCORE_BITS-1:0] wscore;
        logic                  wprs;
        logic                  wpos_en;
        logic                  wscore_en;
        logic                  wprs_en;
        logic [NODE_W-1:0]     raddr;
    } t_nreq;
endpackage

@@ hw/rtl/imhdp_heap_ram.sv @@
module imhdp_heap_ram (
    input  logic                  i_clk,
    input  imhdp_pkg::t_hreq      i_req,
    output logic [imhdp_pkg::NODE_W-1:0] o_rdata
);
    import imhdp_pkg::*;
    logic [NODE_W-1:0] r_mem [NODES];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

@@ hw/rtl/imhdp_node_ram.sv @@
module imhdp_node_ram (
    input  logic                  i_clk,
    input  imhdp_pkg::t_nreq      i_req,
    output logic [imhdp_pkg::NODE_W-1:0]     o_pos,
    output logic [imhdp_pkg::SCORE_BITS-1:0] o_score,
    output logic                             o_prs
);
    import imhdp_pkg::*;
    logic [NODE_W-1:0]     r_pos   [NODES];
    logic [SCORE_BITS-1:0] r_score [NODES];
    logic                  r_prs   [NODES];
    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.wpos_en) begin
            r_pos[i_req.waddr] <= i_req.wpos;
        end
        if (i_req.we && i_req.wscore_en) begin
            r_score[i_req.waddr] <= i_req.wscore;
        end
        if (i_req.we && i_req.wprs_en) begin
            r_prs[i_req.waddr] <= i_req.wprs;
        end
        o_pos   <= r_pos[i_req.raddr];
        o_score <= r_score[i_req.raddr];
        o_prs   <= r_prs[i_req.raddr];
    end
endmodule

@@ hw/rtl/indexed_min_heap_degree_peel_unit.sv @@
// Flow: an input beat reads its node, acts on it, sifts it up and/or down, ten levels at most
//   for 1024 nodes, then reads slot 0 and loads the result; it waits while a result is held.
// Throughput: one beat in flight; the next input is taken the cycle after the result loads.
// Reset: synchronous active low, then a pass over all 1024 nodes clears the presence bits
//   with o_ready low; heap, position and score memories are not cleared.
module indexed_min_heap_degree_peel_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  imhdp_pkg::t_in      i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output imhdp_pkg::t_out     o_data
);
    import imhdp_pkg::*;

    localparam int SW = NODE_W + 2;

    localparam logic [4:0] S_CLR   = 5'd0;  // clear presence bits
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;  // read node pos/score/presence
    localparam logic [4:0] S_ACT   = 5'd3;
    localparam logic [4:0] S_RMV1  = 5'd4;  // last slot node -> read its score
    localparam logic [4:0] S_RMV2  = 5'd5;
    localparam logic [4:0] S_UPA   = 5'd6;  // read parent slot
    localparam logic [4:0] S_UPB   = 5'd7;  // parent node -> read its score
    localparam logic [4:0] S_UPC   = 5'd8;  // compare
    localparam logic [4:0] S_DNA   = 5'd9;  // read left slot
    localparam logic [4:0] S_DNB   = 5'd10; // left node -> score; read right slot
    localparam logic [4:0] S_DNC   = 5'd11; // left score; right node -> score
    localparam logic [4:0] S_DND   = 5'd12; // right score, compare
    localparam logic [4:0] S_FIN0  = 5'd13; // read slot 0
    localparam logic [4:0] S_FIN1  = 5'd14;
    localparam logic [4:0] S_FIN2  = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0]            r_state, n_state;
    logic [NODE_W-1:0]     r_clr, n_clr;
    t_in                   r_in, n_in;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [NODE_W-1:0]     r_nd, n_nd;      // node being sifted
    logic [SCORE_BITS-1:0] r_sc, n_sc;      // its score
    logic [NODE_W-1:0]     r_slot, n_slot;  // current slot
    logic                  r_dn_after, n_dn_after;
    logic [NODE_W-1:0]     r_pn, n_pn;
    logic [NODE_W-1:0]     r_ln, n_ln;
    logic [NODE_W-1:0]     r_rn, n_rn;
    logic [SCORE_BITS-1:0] r_ls, n_ls;
    logic [NODE_W-1:0]     r_nn, n_nn;
    logic [SCORE_BITS-1:0] r_ms, n_ms;
    logic                  r_ovalid, n_ovalid;
    t_out                  r_out, n_out;

    t_hreq                 w_hreq;
    t_nreq                 w_nreq;
    logic [NODE_W-1:0]     w_hrd, w_prd;
    logic [SCORE_BITS-1:0] w_srd;
    logic                  w_prs;

    imhdp_heap_ram u_heap (.i_clk(i_clk), .i_req(w_hreq), .o_rdata(w_hrd));
    imhdp_node_ram u_node (
        .i_clk   (i_clk),
        .i_req   (w_nreq),
        .o_pos   (w_prd),
        .o_score (w_srd),
        .o_prs   (w_prs)
    );

    function automatic logic ranks_first(input logic [SCORE_BITS-1:0] sa,
                                         input logic [NODE_W-1:0]     na,
                                         input logic [SCORE_BITS-1:0] sb,
                                         input logic [NODE_W-1:0]     nb);
        return (sa < sb) || ((sa == sb) && (na < nb));
    endfunction

    logic [SW-1:0]         w_l, w_r;
    logic [NODE_W-1:0]     w_par;
    logic                  w_lok, w_rok;
    logic                  w_take_l, w_take_r;
    logic [CNT_W-1:0]      w_last;
    logic [SCORE_BITS-1:0] w_dec;

    assign w_l    = {1'b0, r_slot, 1'b1};
    assign w_r    = w_l + SW'(1);
    assign w_par  = (r_slot - NODE_W'(1)) >> 1;
    assign w_lok  = w_l < {1'b0, r_cnt};
    assign w_rok  = w_r < {1'b0, r_cnt};
    assign w_last = r_cnt - CNT_W'(1);
    assign w_dec  = (w_srd != '0) ? w_srd - SCORE_BITS'(1) : w_srd;

    always_comb begin
        w_take_l = w_lok && ranks_first(r_ls, r_ln, r_sc, r_nd);
        w_take_r = w_rok && (w_take_l ? ranks_first(w_srd, r_rn, r_ls, r_ln)
                                      : ranks_first(w_srd, r_rn, r_sc, r_nd));
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_in       = r_in;
        n_cnt      = r_cnt;
        n_nd       = r_nd;
        n_sc       = r_sc;
        n_slot     = r_slot;
        n_dn_after = r_dn_after;
        n_pn       = r_pn;
        n_ln       = r_ln;
        n_rn       = r_rn;
        n_ls       = r_ls;
        n_nn       = r_nn;
        n_ms       = r_ms;
        n_out      = r_out;
        n_ovalid   = (r_ovalid && i_ready) ? 1'b0 : r_ovalid;
        w_hreq     = '0;
        w_nreq     = '0;
        w_nreq.raddr = r_in.node;
        case (r_state)
            S_CLR: begin
                w_nreq.we = 1'b1; w_nreq.waddr = r_clr; w_nreq.wprs_en = 1'b1;
                n_clr = r_clr + NODE_W'(1);
                if (r_clr == NODE_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_in    = i_data;
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_ACT;
            S_ACT: begin
                n_nd = r_in.node;
                case (r_in.action)
                    ACT_LOAD: begin
                        w_nreq.we = 1'b1; w_nreq.waddr = r_in.node;
                        w_nreq.wscore = r_in.score; w_nreq.wscore_en = 1'b1;
                        n_sc = r_in.score;
                        if (w_prs) begin
                            n_slot = w_prd; n_dn_after = 1'b1;
                            n_state = S_UPA;
                        end else if (r_cnt < CNT_W'(NODES)) begin
                            w_nreq.wprs = 1'b1; w_nreq.wprs_en = 1'b1;
                            n_slot = r_cnt[NODE_W-1:0];
                            n_cnt = r_cnt + CNT_W'(1);
                            n_dn_after = 1'b0;
                            n_state = S_UPA;
                        end else begin
                            n_state = S_FIN0;
                        end
                    end
                    ACT_REMOVE: begin
                        w_hreq.raddr = w_last[NODE_W-1:0];
                        if (w_prs) begin
                            w_nreq.we = 1'b1; w_nreq.waddr = r_in.node;
                            w_nreq.wprs_en = 1'b1;
                            n_slot = w_prd;
                            n_cnt = w_last;
                            n_dn_after = 1'b1;
                            n_state = ({1'b0, w_prd} < w_last) ? S_RMV1 : S_FIN0;
                        end else begin
                            n_state = S_FIN0;
                        end
                    end
                    ACT_DEC: begin
                        w_nreq.we = 1'b1; w_nreq.waddr = r_in.node;
                        w_nreq.wscore = w_dec; w_nreq.wscore_en = 1'b1;
                        n_sc = w_dec;
                        n_dn_after = 1'b0;
                        if (w_prs) begin
                            n_slot = w_prd;
                            n_state = S_UPA;
                        end else begin
                            n_state = S_FIN0;
                        end
                    end
                    default: n_state = S_FIN0;
                endcase
            end
            S_RMV1: begin
                n_nd = w_hrd;
                w_nreq.raddr = w_hrd;
                n_state = S_RMV2;
            end
            S_RMV2: begin
                n_sc = w_srd;
                n_state = S_UPA;
            end
            S_UPA: begin
                if (r_slot == '0) begin
                    w_hreq.we = 1'b1; w_hreq.waddr = r_slot; w_hreq.wdata = r_nd;
                    w_nreq.we = 1'b1; w_nreq.waddr = r_nd; w_nreq.wpos = r_slot;
                    w_nreq.wpos_en = 1'b1;
                    n_state = r_dn_after ? S_DNA : S_FIN0;
                end else begin
                    w_hreq.raddr = w_par;
                    n_state = S_UPB;
                end
            end
            S_UPB: begin
                n_pn = w_hrd;
                w_nreq.raddr = w_hrd;
                n_state = S_UPC;
            end
            S_UPC: begin
                w_hreq.we = 1'b1; w_hreq.waddr = r_slot;
                w_nreq.we = 1'b1; w_nreq.wpos = r_slot; w_nreq.wpos_en = 1'b1;
                if (ranks_first(r_sc, r_nd, w_srd, r_pn)) begin
                    w_hreq.wdata = r_pn; w_nreq.waddr = r_pn;
                    n_slot = w_par;
                    n_state = S_UPA;
                end else begin
                    w_hreq.wdata = r_nd; w_nreq.waddr = r_nd;
                    n_state = r_dn_after ? S_DNA : S_FIN0;
                end
            end
            S_DNA: begin
                if (w_lok) begin
                    w_hreq.raddr = w_l[NODE_W-1:0];
                    n_state = S_DNB;
                end else begin
                    w_hreq.we = 1'b1; w_hreq.waddr = r_slot; w_hreq.wdata = r_nd;
                    w_nreq.we = 1'b1; w_nreq.waddr = r_nd; w_nreq.wpos = r_slot;
                    w_nreq.wpos_en = 1'b1;
                    n_state = S_FIN0;
                end
            end
            S_DNB: begin
                n_ln = w_hrd;
                w_nreq.raddr = w_hrd;
                w_hreq.raddr = w_r[NODE_W-1:0];
                n_state = S_DNC;
            end
            S_DNC: begin
                n_ls = w_srd;
                n_rn = w_hrd;
                w_nreq.raddr = w_hrd;
                n_state = S_DND;
            end
            S_DND: begin
                w_hreq.we = 1'b1; w_hreq.waddr = r_slot;
                w_nreq.we = 1'b1; w_nreq.wpos = r_slot; w_nreq.wpos_en = 1'b1;
                if (w_take_r) begin
                    w_hreq.wdata = r_rn; w_nreq.waddr = r_rn;
                    n_slot = w_r[NODE_W-1:0];
                    n_state = S_DNA;
                end else if (w_take_l) begin
                    w_hreq.wdata = r_ln; w_nreq.waddr = r_ln;
                    n_slot = w_l[NODE_W-1:0];
                    n_state = S_DNA;
                end else begin
                    w_hreq.wdata = r_nd; w_nreq.waddr = r_nd;
                    n_state = S_FIN0;
                end
            end
            S_FIN0: begin
                w_hreq.raddr = '0;
                n_state = S_FIN1;
            end
            S_FIN1: begin
                n_nn = w_hrd;
                w_nreq.raddr = w_hrd;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_ms = w_srd;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_out.min_node  = (r_cnt == '0) ? '0 : r_nn;
                    n_out.min_score = (r_cnt == '0) ? '0 : r_ms;
                    n_out.count     = r_cnt;
                    n_out.empty_res = (r_cnt == '0);
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_in     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_out    <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_in     <= n_in;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_out    <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nd       <= n_nd;
        r_sc       <= n_sc;
        r_slot     <= n_slot;
        r_dn_after <= n_dn_after;
        r_pn       <= n_pn;
        r_ln       <= n_ln;
        r_rn       <= n_rn;
        r_ls       <= n_ls;
        r_nn       <= n_nn;
        r_ms       <= n_ms;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;
endmodule
